// ===== rtl/bcfm_pkg.sv =====
// Package for the binary chirp frame modulator: defaults, codes, types and the cosine builder.
package bcfm_pkg;

    // Defaults for the top-level parameters
    localparam int TABLE_ADDR_BITS_DEF = 10;
    localparam int PHASE_BITS_DEF      = 32;
    localparam int SAMPLE_BITS_DEF     = 16;
    localparam int PREAMBLE_UP_DEF     = 8;
    localparam int PREAMBLE_DOWN_DEF   = 2;

    // Fixed widths of the input stream and the register file
    localparam int IN_DW   = 8;
    localparam int CFG_DW  = 32;
    localparam int CFG_AW  = 4;
    localparam int STEP_W  = 32;
    localparam int LEN_W   = 16;
    localparam int AMP_W   = 15;

    // Register reset values
    localparam logic [LEN_W-1:0] SYMBOL_LEN_RST = 16'd1024;
    localparam logic [AMP_W-1:0] AMPLITUDE_RST  = 15'd32767;

    // Register indexes (paddr[3:2])
    typedef logic [1:0] reg_idx_t;
    localparam reg_idx_t REG_START_STEP  = 2'd0;
    localparam reg_idx_t REG_CHIRP_CURVE = 2'd1;
    localparam reg_idx_t REG_SYMBOL_LEN  = 2'd2;
    localparam reg_idx_t REG_AMPLITUDE   = 2'd3;

    // Segment codes
    typedef logic [1:0] seg_t;
    localparam seg_t SEG_IDLE     = 2'd0;
    localparam seg_t SEG_PRE_UP   = 2'd1;
    localparam seg_t SEG_PRE_DOWN = 2'd2;
    localparam seg_t SEG_DATA     = 2'd3;

    // Per-sample control flags that ride along with the table lookup
    typedef struct packed {
        logic active;
        logic taken;
        seg_t seg;
        logic fend;
    } meta_t;

    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] ONE_Q30     = 64'd1 << 30;

    // Quarter-wave cosine magnitude, scaled to tmax and rounded; elaboration use only
    function automatic logic [63:0] cos_mag(input int unsigned m, input int unsigned qbits,
                                            input logic [63:0] tmax);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] sum;
        logic [63:0] term;
        logic [63:0] mag;
        x    = (64'(m) * HALF_PI_Q30) >> qbits;
        x2   = (x * x) >> 30;
        sum  = ONE_Q30;
        term = ONE_Q30;
        for (int k = 1; k <= 8; k++) begin
            term = ((term * x2) >> 30) / 64'((2 * k - 1) * (2 * k));
            if ((k % 2) == 1)
                sum = sum - term;
            else
                sum = sum + term;
        end
        if (sum > (64'd1 << 62))
            sum = 64'd0;
        if (sum > ONE_Q30)
            sum = ONE_Q30;
        mag = (sum * tmax + (ONE_Q30 >> 1)) >> 30;
        if (mag > tmax)
            mag = tmax;
        return mag;
    endfunction

endpackage

// ===== rtl/bcfm_cos_rom.sv =====
// Quarter-wave cosine table with quadrant folding: phase index in, magnitude and sign out.
module bcfm_cos_rom #(
    parameter int ADDR_BITS = bcfm_pkg::TABLE_ADDR_BITS_DEF,
    parameter int MAG_BITS  = bcfm_pkg::SAMPLE_BITS_DEF - 1
) (
    input  logic [ADDR_BITS-1:0] addr,
    output logic [MAG_BITS-1:0]  mag,
    output logic                 neg
);
    import bcfm_pkg::*;

    localparam int          QB   = ADDR_BITS - 2;
    localparam int          Q    = 1 << QB;
    localparam logic [63:0] TMAX = (64'd1 << MAG_BITS) - 64'd1;

    logic [MAG_BITS-1:0] tab [Q+1];
    logic [1:0]          quad;
    logic [QB-1:0]       r;
    logic [QB:0]         m;

    // Build the constant quarter wave, endpoint included
    for (genvar g = 0; g <= Q; g++) begin : g_tab
        localparam logic [MAG_BITS-1:0] V = MAG_BITS'(cos_mag(g, QB, TMAX));
        assign tab[g] = V;
    end

    // Fold the phase into the first quadrant
    assign quad = addr[ADDR_BITS-1 -: 2];
    assign r    = addr[QB-1:0];
    assign m    = quad[0] ? ((QB+1)'(Q) - {1'b0, r}) : {1'b0, r};
    assign mag  = tab[m];
    assign neg  = quad[1] ^ quad[0];

endmodule

// ===== rtl/binary_chirp_frame_modulator.sv =====
// Top level of the binary chirp frame modulator: frame sequencer, chirp oscillator, output pipe.
//
// The block takes one item per clock, unless the output stalls, and returns one sample item
// for each. The result passes through the s1, s2 and output registers before it is presented.
// A start item (tuser = 1) opens a frame of PREAMBLE_UP up-chirps and PREAMBLE_DOWN
// down-chirps, after which each symbol boundary samples more_bits and latches data_bit
// (0 up, 1 down) or ends the frame. The sequencer and the quadratic-phase oscillator (phase
// and frequency adders of PHASE_BITS) update in the cycle an item is taken, so the rate is
// one item per clock unless the output stalls; the cosine lookup and the amplitude multiply
// follow in two registered stages. Configuration is written over APB at byte addresses 0
// (start_step), 4 (chirp_curve), 8 (symbol_len), 12 (amplitude); the user must write it only
// while no item is in flight, which the block does not enforce; a change inside a frame
// applies from the next item on. A symbol_len of zero gives 65536-sample chirps.
module binary_chirp_frame_modulator #(
    parameter int TABLE_ADDR_BITS = bcfm_pkg::TABLE_ADDR_BITS_DEF,
    parameter int PHASE_BITS      = bcfm_pkg::PHASE_BITS_DEF,
    parameter int SAMPLE_BITS     = bcfm_pkg::SAMPLE_BITS_DEF,
    parameter int PREAMBLE_UP     = bcfm_pkg::PREAMBLE_UP_DEF,
    parameter int PREAMBLE_DOWN   = bcfm_pkg::PREAMBLE_DOWN_DEF,
    parameter int OUT_DW          = ((SAMPLE_BITS + 2 + 7) / 8) * 8
) (
    input  logic                        clk,
    input  logic                        rst_n,
    // input stream
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [bcfm_pkg::IN_DW-1:0]  s_axis_tdata,  // [0] data_bit, [1] more_bits
    input  logic                        s_axis_tuser,  // [0] kind
    // output stream
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [OUT_DW-1:0]           m_axis_tdata,  // sample, active, bit_taken
    output logic [1:0]                  m_axis_tuser,  // [1:0] segment
    output logic                        m_axis_tlast,  // frame_end
    // configuration
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [bcfm_pkg::CFG_AW-1:0] paddr,
    input  logic [bcfm_pkg::CFG_DW-1:0] pwdata,
    output logic [bcfm_pkg::CFG_DW-1:0] prdata,
    output logic                        pready
);
    import bcfm_pkg::*;

    localparam int PRE_TOTAL = PREAMBLE_UP + PREAMBLE_DOWN;
    localparam int PC_W      = $clog2(PRE_TOTAL + 1);
    localparam int MAG_W     = SAMPLE_BITS - 1;
    localparam int UP_SH     = (PHASE_BITS >= STEP_W) ? (PHASE_BITS - STEP_W) : 0;
    localparam int DN_SH     = (PHASE_BITS < STEP_W) ? (STEP_W - PHASE_BITS) : 0;
    localparam int WIDE_W    = STEP_W + 48;
    localparam int PROD_W    = MAG_W + AMP_W + 1;

    // Configuration registers
    logic [STEP_W-1:0] start_step_reg;
    logic [STEP_W-1:0] chirp_curve_reg;
    logic [LEN_W-1:0]  symbol_len_reg;
    logic [AMP_W-1:0]  amplitude_reg;

    // Oscillator and sequencer state
    logic [PHASE_BITS-1:0] phase_acc_reg, phase_acc_next;
    logic [PHASE_BITS-1:0] freq_word_reg, freq_word_next;
    logic [LEN_W-1:0]      sample_index_reg, sample_index_next;
    logic [PC_W-1:0]       preamble_count_reg, preamble_count_next;
    logic                  downward_reg, downward_next;
    logic                  in_frame_reg, in_frame_next;

    // Pipeline stages
    logic                       s1_valid_reg, s1_valid_next;
    logic [TABLE_ADDR_BITS-1:0] s1_idx_reg;
    meta_t                      s1_meta_reg;
    logic                       s2_valid_reg, s2_valid_next;
    logic [MAG_W-1:0]           s2_mag_reg;
    logic                       s2_neg_reg;
    meta_t                      s2_meta_reg;
    logic                       out_valid_reg, out_valid_next;
    logic [SAMPLE_BITS-1:0]     out_sample_reg;
    meta_t                      out_meta_reg;

    logic                       accept;
    logic                       out_ok, s2_ok, s1_ok;
    logic                       s2_load, out_load;
    logic                       cfg_wr;
    reg_idx_t                   cfg_idx;

    logic [WIDE_W-1:0]          s_wide, c_wide;
    logic [PHASE_BITS-1:0]      s_ph, c_ph, two_c;
    logic [PHASE_BITS-1:0]      ph_cur, fw_cur;
    logic [LEN_W-1:0]           si_cur, last_idx;
    logic [PC_W-1:0]            pc_cur, pc_inc;
    logic                       dn_cur, inf_cur;
    logic                       kind, data_bit, more_bits;
    meta_t                      meta_new;
    logic [TABLE_ADDR_BITS-1:0] idx_new;

    logic [MAG_W-1:0]           rom_mag;
    logic                       rom_neg;
    logic [PROD_W-1:0]          prod;
    logic [MAG_W-1:0]           scaled;
    logic [SAMPLE_BITS-1:0]     sample_new;

    // APB register file
    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite;
    assign cfg_idx = paddr[3:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_step_reg  <= '0;
            chirp_curve_reg <= '0;
            symbol_len_reg  <= SYMBOL_LEN_RST;
            amplitude_reg   <= AMPLITUDE_RST;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                REG_START_STEP:  start_step_reg  <= pwdata;
                REG_CHIRP_CURVE: chirp_curve_reg <= pwdata;
                REG_SYMBOL_LEN:  symbol_len_reg  <= pwdata[LEN_W-1:0];
                REG_AMPLITUDE:   amplitude_reg   <= pwdata[AMP_W-1:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            REG_START_STEP:  prdata = start_step_reg;
            REG_CHIRP_CURVE: prdata = chirp_curve_reg;
            REG_SYMBOL_LEN:  prdata = CFG_DW'(symbol_len_reg);
            REG_AMPLITUDE:   prdata = CFG_DW'(amplitude_reg);
            default:         prdata = '0;
        endcase
    end

    // Scale the 32-bit turn fractions to the phase width
    assign s_wide   = (WIDE_W'(start_step_reg) << UP_SH) >> DN_SH;
    assign c_wide   = (WIDE_W'(chirp_curve_reg) << UP_SH) >> DN_SH;
    assign s_ph     = s_wide[PHASE_BITS-1:0];
    assign c_ph     = c_wide[PHASE_BITS-1:0];
    assign two_c    = {c_ph[PHASE_BITS-2:0], 1'b0};
    assign last_idx = symbol_len_reg - LEN_W'(1);

    // Pipeline flow: each stage moves when the one after it is empty or moving
    assign out_ok        = !out_valid_reg || m_axis_tready;
    assign s2_ok         = !s2_valid_reg || out_ok;
    assign s1_ok         = !s1_valid_reg || s2_ok;
    assign s_axis_tready = s1_ok;
    assign accept        = s_axis_tvalid && s1_ok;
    assign s2_load       = s1_valid_reg && s2_ok;
    assign out_load      = s2_valid_reg && out_ok;

    assign s1_valid_next  = accept || (s1_valid_reg && !s2_ok);
    assign s2_valid_next  = s2_load || (s2_valid_reg && !out_ok);
    assign out_valid_next = out_load || (out_valid_reg && !m_axis_tready);

    assign kind      = s_axis_tuser;
    assign data_bit  = s_axis_tdata[0];
    assign more_bits = s_axis_tdata[1];

    // Frame sequencer and oscillator step for the item being taken
    always_comb
    begin
        inf_cur = kind || in_frame_reg;
        pc_cur  = kind ? '0 : preamble_count_reg;
        dn_cur  = kind ? 1'b0 : downward_reg;
        si_cur  = kind ? '0 : sample_index_reg;
        ph_cur  = kind ? '0 : phase_acc_reg;
        fw_cur  = kind ? (s_ph + c_ph) : freq_word_reg;
        pc_inc  = (32'(pc_cur) < PRE_TOTAL) ? (pc_cur + PC_W'(1)) : pc_cur;

        phase_acc_next      = ph_cur;
        freq_word_next      = fw_cur;
        sample_index_next   = si_cur;
        preamble_count_next = pc_cur;
        downward_next       = dn_cur;
        in_frame_next       = inf_cur;

        meta_new = '0;
        idx_new  = ph_cur[PHASE_BITS-1 -: TABLE_ADDR_BITS];

        if (inf_cur)
        begin
            meta_new.active = 1'b1;
            if (32'(pc_cur) < PREAMBLE_UP)
                meta_new.seg = SEG_PRE_UP;
            else if (32'(pc_cur) < PRE_TOTAL)
                meta_new.seg = SEG_PRE_DOWN;
            else
                meta_new.seg = SEG_DATA;

            phase_acc_next = ph_cur + fw_cur;
            freq_word_next = dn_cur ? (fw_cur - two_c) : (fw_cur + two_c);

            if (si_cur >= last_idx)
            begin
                // Symbol boundary: pick the next chirp or close the frame
                sample_index_next   = '0;
                preamble_count_next = pc_inc;
                if (32'(pc_inc) < PREAMBLE_UP)
                    downward_next = 1'b0;
                else if (32'(pc_inc) < PRE_TOTAL)
                    downward_next = 1'b1;
                else if (more_bits)
                begin
                    downward_next  = data_bit;
                    meta_new.taken = 1'b1;
                end
                else
                begin
                    meta_new.fend = 1'b1;
                    in_frame_next = 1'b0;
                end
                phase_acc_next = '0;
                freq_word_next = downward_next ? (s_ph - c_ph) : (s_ph + c_ph);
                if (!in_frame_next)
                begin
                    freq_word_next = '0;
                    downward_next  = 1'b0;
                end
            end
            else
            begin
                sample_index_next = si_cur + LEN_W'(1);
            end
        end
    end

    // Hold the oscillator and sequencer state between taken items
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_acc_reg      <= '0;
            freq_word_reg      <= '0;
            sample_index_reg   <= '0;
            preamble_count_reg <= '0;
            downward_reg       <= 1'b0;
            in_frame_reg       <= 1'b0;
        end
        else if (accept)
        begin
            phase_acc_reg      <= phase_acc_next;
            freq_word_reg      <= freq_word_next;
            sample_index_reg   <= sample_index_next;
            preamble_count_reg <= preamble_count_next;
            downward_reg       <= downward_next;
            in_frame_reg       <= in_frame_next;
        end
    end

    // Cosine lookup on the registered phase index
    bcfm_cos_rom #(
        .ADDR_BITS (TABLE_ADDR_BITS),
        .MAG_BITS  (MAG_W)
    ) u_cos_rom (
        .addr (s1_idx_reg),
        .mag  (rom_mag),
        .neg  (rom_neg)
    );

    // Scale by amplitude, round half away from zero, restore the sign
    assign prod       = PROD_W'(s2_mag_reg) * PROD_W'(amplitude_reg) + PROD_W'(1 << 14);
    assign scaled     = prod[AMP_W +: MAG_W];
    assign sample_new = s2_neg_reg ? (SAMPLE_BITS'(0) - {1'b0, scaled}) : {1'b0, scaled};

    // Stage valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            s2_valid_reg  <= s2_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Stage payloads
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_idx_reg  <= idx_new;
            s1_meta_reg <= meta_new;
        end
        if (s2_load)
        begin
            s2_mag_reg  <= s1_meta_reg.active ? rom_mag : '0;
            s2_neg_reg  <= rom_neg;
            s2_meta_reg <= s1_meta_reg;
        end
        if (out_load)
        begin
            out_sample_reg <= sample_new;
            out_meta_reg   <= s2_meta_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = OUT_DW'({out_meta_reg.taken, out_meta_reg.active, out_sample_reg});
    assign m_axis_tuser  = out_meta_reg.seg;
    assign m_axis_tlast  = out_meta_reg.fend;

    // An idle oscillator holds zero phase and frequency
    a_idle_osc_clear: assert property (@(posedge clk) disable iff (!rst_n)
        !in_frame_reg |-> (phase_acc_reg == '0) && (freq_word_reg == '0) && !downward_reg)
        else $error("oscillator not cleared while idle");

    // Frame end and bit latch only come with an active sample
    a_flags_active: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tlast || out_meta_reg.taken) |-> out_meta_reg.active)
        else $error("frame flag on an idle sample");

    // Idle samples are zero with the idle segment
    a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !out_meta_reg.active |->
            (out_sample_reg == '0) && (out_meta_reg.seg == SEG_IDLE))
        else $error("idle sample not zero");

    // A finished frame leaves the block idle
    a_fend_idle: assert property (@(posedge clk) disable iff (!rst_n)
        accept && meta_new.fend |=> !in_frame_reg)
        else $error("frame did not close");

    // A stalled result stays in place
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(out_sample_reg))
        else $error("stalled result changed");

endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for the binary chirp frame modulator: streams ticks, predicts samples.
`timescale 1ns / 100ps

module testbench;

    import bcfm_pkg::*;

    localparam int OUT_W          = ((SAMPLE_BITS_DEF + 2 + 7) / 8) * 8;
    localparam int PRE_UP         = PREAMBLE_UP_DEF;
    localparam int PRE_TOTAL      = PREAMBLE_UP_DEF + PREAMBLE_DOWN_DEF;
    localparam int QBITS          = TABLE_ADDR_BITS_DEF - 2;
    localparam int TBL_DEPTH      = 1 << TABLE_ADDR_BITS_DEF;
    localparam int DRAIN_CYCLES   = 8;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam longint unsigned QUARTER_TURN = 64'd1686629713;
    localparam longint unsigned UNITY_Q30    = 64'd1 << 30;
    localparam longint unsigned PEAK         = 64'd32767;

    // One input tick and one output sample item
    typedef struct packed {
        logic kind;
        logic data_bit;
        logic more_bits;
    } tick_t;

    typedef struct packed {
        logic [15:0] sample;
        logic        active;
        logic        taken;
        seg_t        seg;
        logic        fend;
    } chirp_out_t;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             s_axis_tvalid = 1'b0;
    logic             s_axis_tready;
    logic [IN_DW-1:0] s_axis_tdata = '0;   // [0] data_bit, [1] more_bits
    logic             s_axis_tuser = 1'b0; // [0] kind
    logic             m_axis_tvalid;
    logic             m_axis_tready = 1'b0;
    logic [OUT_W-1:0] m_axis_tdata;        // [15:0] sample, [16] active, [17] bit_taken
    logic [1:0]       m_axis_tuser;        // [1:0] segment
    logic             m_axis_tlast;        // frame_end
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [CFG_AW-1:0] paddr = '0;
    logic [CFG_DW-1:0] pwdata = '0;
    logic [CFG_DW-1:0] prdata;
    logic              pready;

    binary_chirp_frame_modulator DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // Predictor copy of the registers and the oscillator/sequencer state
    logic [31:0] cfg_step;
    logic [31:0] cfg_curve;
    logic [15:0] cfg_len;
    logic [14:0] cfg_amp;
    logic [31:0] osc_phase;
    logic [31:0] osc_freq;
    logic [15:0] chirp_pos;
    int          pre_done;
    logic        going_down;
    logic        framing;
    logic signed [15:0] cos_tbl [0:TBL_DEPTH-1];

    tick_t      tick_queue[$];
    chirp_out_t chirp_sample_q[$];
    tick_t      drive_tick;
    int         ticks_pushed = 0;
    int         ticks_taken = 0;
    int         errors = 0;
    int         idle_cycles = 0;
    int         in_idle_pct = 25;
    int         out_idle_pct = 25;

    // Cosine entry k, built from a quarter wave with a truncated Taylor series in Q30
    function automatic logic signed [15:0] cos_entry(int unsigned k);
        int unsigned quad;
        int n;
        longint unsigned r;
        longint unsigned m;
        longint unsigned x;
        longint unsigned x2;
        longint unsigned acc;
        longint unsigned term;
        longint unsigned mag;
        logic signed [15:0] val;
        quad = k >> QBITS;
        r    = k & ((1 << QBITS) - 1);
        m    = (quad & 1) ? ((64'd1 << QBITS) - r) : r;
        x    = (m * QUARTER_TURN) >> QBITS;
        x2   = (x * x) >> 30;
        acc  = UNITY_Q30;
        term = UNITY_Q30;
        for (n = 1; n <= 8; n++)
        begin
            term = ((term * x2) >> 30) / longint'((2 * n - 1) * (2 * n));
            acc  = (n % 2 == 1) ? acc - term : acc + term;
        end
        // clamp a slight wrap below zero and any overshoot above one
        if (acc > (64'd1 << 62))
            acc = 0;
        if (acc > UNITY_Q30)
            acc = UNITY_Q30;
        mag = (acc * PEAK + (UNITY_Q30 >> 1)) >> 30;
        if (mag > PEAK)
            mag = PEAK;
        val = 16'(mag);
        if (quad == 1 || quad == 2)
            val = -val;
        return val;
    endfunction

    function automatic int samples_per_symbol();
        return (cfg_len == 16'd0) ? 65536 : int'(cfg_len);
    endfunction

    // Reload the oscillator for a new chirp in the current direction
    function automatic void restart_chirp();
        osc_phase = '0;
        osc_freq  = going_down ? cfg_step - cfg_curve : cfg_step + cfg_curve;
    endfunction

    // Advance the modulator by one tick and return the sample it emits
    function automatic void next_chirp_sample(input tick_t tk, output chirp_out_t res);
        logic signed [15:0] t;
        logic [15:0] mag;
        logic [31:0] scaled;
        logic [15:0] last_pos;
        res = '0;
        if (tk.kind)
        begin
            pre_done   = 0;
            going_down = 1'b0;
            chirp_pos  = '0;
            framing    = 1'b1;
            restart_chirp();
        end
        if (framing)
        begin
            t      = cos_tbl[osc_phase[31:32-TABLE_ADDR_BITS_DEF]];
            mag    = (t < 0) ? 16'(-t) : 16'(t);
            scaled = (32'(mag) * 32'(cfg_amp) + 32'd16384) >> 15;
            res.active = 1'b1;
            res.seg    = (pre_done < PRE_UP) ? SEG_PRE_UP :
                         (pre_done < PRE_TOTAL) ? SEG_PRE_DOWN : SEG_DATA;
            res.sample = (t < 0) ? 16'(-scaled) : scaled[15:0];
            osc_phase  = osc_phase + osc_freq;
            osc_freq   = going_down ? osc_freq - (cfg_curve << 1) : osc_freq + (cfg_curve << 1);
            last_pos   = cfg_len - 16'd1;
            if (chirp_pos >= last_pos)
            begin
                // symbol boundary: pick the next direction or end the frame
                chirp_pos = '0;
                if (pre_done < PRE_TOTAL)
                    pre_done++;
                if (pre_done < PRE_UP)
                    going_down = 1'b0;
                else if (pre_done < PRE_TOTAL)
                    going_down = 1'b1;
                else if (tk.more_bits)
                begin
                    going_down = tk.data_bit;
                    res.taken  = 1'b1;
                end
                else
                begin
                    res.fend = 1'b1;
                    framing  = 1'b0;
                end
                restart_chirp();
                if (!framing)
                begin
                    osc_phase  = '0;
                    osc_freq   = '0;
                    going_down = 1'b0;
                end
            end
            else
                chirp_pos = chirp_pos + 16'd1;
        end
    endfunction

    // Clock
    initial
    begin
        forever #4 clk = ~clk;
    end

    // Drive input ticks from the pending queue, predict each accepted item
    always @(posedge clk)
    begin
        chirp_out_t res;
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                next_chirp_sample(drive_tick, res);
                chirp_sample_q.push_back(res);
                ticks_taken++;
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (tick_queue.size() > 0 && $urandom_range(0, 99) >= in_idle_pct)
                begin
                    drive_tick    = tick_queue.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {6'b0, drive_tick.more_bits, drive_tick.data_bit};
                    s_axis_tuser  <= drive_tick.kind;
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Compare each sample item with the oldest prediction
    always @(posedge clk)
    begin
        chirp_out_t want;
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (chirp_sample_q.size() == 0)
                begin
                    $error("sample item with no prediction waiting");
                    errors++;
                end
                else
                begin
                    want = chirp_sample_q.pop_front();
                    if (m_axis_tdata[15:0] !== want.sample)
                    begin
                        $error("sample: expected %0d, got %0d",
                               $signed(want.sample), $signed(m_axis_tdata[15:0]));
                        errors++;
                    end
                    if (m_axis_tdata[16] !== want.active)
                    begin
                        $error("active: expected %0d, got %0d", want.active, m_axis_tdata[16]);
                        errors++;
                    end
                    if (m_axis_tdata[17] !== want.taken)
                    begin
                        $error("bit_taken: expected %0d, got %0d", want.taken, m_axis_tdata[17]);
                        errors++;
                    end
                    if (m_axis_tuser !== want.seg)
                    begin
                        $error("segment: expected %0d, got %0d", want.seg, m_axis_tuser);
                        errors++;
                    end
                    if (m_axis_tlast !== want.fend)
                    begin
                        $error("frame_end: expected %0d, got %0d", want.fend, m_axis_tlast);
                        errors++;
                    end
                end
            end
            m_axis_tready <= ($urandom_range(0, 99) >= out_idle_pct);
        end
    end

    // Stop the run when no item moves on either side for too long
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    task automatic push_tick(bit kind, bit data_bit, bit more_bits);
        tick_t tk;
        tk.kind      = kind;
        tk.data_bit  = data_bit;
        tk.more_bits = more_bits;
        tick_queue.push_back(tk);
        ticks_pushed++;
    endtask

    // Wait until every queued tick is taken and every sample has come back
    task automatic wait_drain();
        while (ticks_pushed != ticks_taken || chirp_sample_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(reg_idx_t idx, logic [31:0] val);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_START_STEP:  cfg_step  = val;
            REG_CHIRP_CURVE: cfg_curve = val;
            REG_SYMBOL_LEN:  cfg_len   = val[15:0];
            REG_AMPLITUDE:   cfg_amp   = val[14:0];
            default: ;
        endcase
    endtask

    task automatic set_chirp(logic [31:0] step, logic [31:0] curve, logic [15:0] len,
                             logic [14:0] amp);
        write_reg(REG_START_STEP, step);
        write_reg(REG_CHIRP_CURVE, curve);
        write_reg(REG_SYMBOL_LEN, 32'(len));
        write_reg(REG_AMPLITUDE, 32'(amp));
    endtask

    // Queue one frame with nbits data symbols; a nonzero cut truncates it to that many ticks
    task automatic send_frame(int nbits, int cut);
        int len;
        int total;
        int p;
        int j;
        bit d;
        bit m;
        len   = samples_per_symbol();
        total = (PRE_TOTAL + nbits) * len;
        if (cut > 0 && cut < total)
            total = cut;
        for (p = 0; p < total; p++)
        begin
            d = $urandom_range(0, 1);
            m = $urandom_range(0, 1);
            if ((p + 1) % len == 0)
            begin
                j = (p + 1) / len - 1;
                if (j >= PRE_TOTAL - 1)
                    m = (j < PRE_TOTAL - 1 + nbits);
            end
            push_tick(p == 0, d, m);
        end
    endtask

    // Run out any open frame with more_bits low so the block goes idle
    task automatic close_frame();
        wait_drain();
        while (framing)
        begin
            repeat (32) push_tick(0, $urandom_range(0, 1), 0);
            wait_drain();
        end
    endtask

    // Mostly well-formed frames, some cut short, some stray idle ticks
    task automatic run_phase(int target, bit bend);
        int first;
        int sel;
        int nbits;
        int full;
        bit paused;
        first  = ticks_pushed;
        paused = 1'b0;
        while (ticks_pushed - first < target)
        begin
            // hold the sender once until every sample is back
            if (!paused && ticks_pushed - first >= target / 2)
            begin
                paused = 1'b1;
                if (bend)
                begin
                    // bend a running chirp with a new curve
                    send_frame(4, 5 + $urandom_range(0, 20));
                    wait_drain();
                    write_reg(REG_CHIRP_CURVE, $urandom);
                    repeat (3 * samples_per_symbol() + 2)
                        push_tick(0, $urandom_range(0, 1), $urandom_range(0, 1));
                end
                else
                    wait_drain();
            end
            sel   = $urandom_range(0, 99);
            nbits = $urandom_range(0, 12);
            if (sel < 85)
                send_frame(nbits, 0);
            else if (sel < 93)
            begin
                full = (PRE_TOTAL + nbits) * samples_per_symbol();
                send_frame(nbits, $urandom_range(1, full - 1));
            end
            else
                repeat ($urandom_range(1, 6))
                    push_tick(0, $urandom_range(0, 1), $urandom_range(0, 1));
        end
        close_frame();
    endtask

    initial
    begin
        int k;
        int i;
        // Predictor reset state
        for (k = 0; k < TBL_DEPTH; k++)
            cos_tbl[k] = cos_entry(k);
        cfg_step   = '0;
        cfg_curve  = '0;
        cfg_len    = SYMBOL_LEN_RST;
        cfg_amp    = AMPLITUDE_RST;
        osc_phase  = '0;
        osc_freq   = '0;
        chirp_pos  = '0;
        pre_done   = 0;
        going_down = 1'b0;
        framing    = 1'b0;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Idle ticks give all-zero samples
        push_tick(0, 0, 0);
        push_tick(0, 1, 1);
        wait_drain();

        // One-sample chirps: full frame with bits 0 and 1, then end
        set_chirp(32'h0400_0000, 32'h0001_0000, 16'd1, 15'd32767);
        push_tick(1, 1, 1);
        for (i = 1; i <= 8; i++)
            push_tick(0, i[0], !i[0]);
        push_tick(0, 0, 1);
        push_tick(0, 1, 1);
        push_tick(0, 1, 0);
        push_tick(0, 1, 1);
        // restart inside the preamble, then end right after it
        push_tick(1, 0, 0);
        push_tick(0, 1, 0);
        push_tick(1, 1, 1);
        repeat (9) push_tick(0, 0, 0);
        close_frame();

        // Random phases over several register settings
        set_chirp($urandom, $urandom, 16'd1, 15'd32767);
        run_phase(170, 1'b0);
        set_chirp(32'h0000_0000, 32'h7FFF_FFFF, 16'd2, 15'd0);
        run_phase(170, 1'b0);
        in_idle_pct  = 0;
        out_idle_pct = 0;
        set_chirp(32'hFFFF_FFFF, 32'h8000_0000, 16'd3, 15'd1);
        run_phase(170, 1'b0);
        in_idle_pct  = 25;
        out_idle_pct = 25;
        set_chirp($urandom, $urandom, 16'($urandom_range(1, 8)), 15'($urandom_range(0, 32767)));
        run_phase(170, 1'b1);
        for (i = 0; i < 4; i++)
        begin
            set_chirp($urandom, $urandom >> $urandom_range(0, 20),
                      16'($urandom_range(1, 6)), 15'($urandom_range(0, 32767)));
            run_phase(170, i == 2);
        end

        // Zero length means 65536-sample chirps; no boundary comes early
        set_chirp($urandom, $urandom >> 12, 16'd0, 15'($urandom_range(0, 32767)));
        push_tick(1, 0, 0);
        repeat (40) push_tick(0, $urandom_range(0, 1), $urandom_range(0, 1));
        wait_drain();
        // switch lengths inside the running chirp; a shorter one ends it at once
        write_reg(REG_SYMBOL_LEN, 32'd65535);
        repeat (20) push_tick(0, $urandom_range(0, 1), $urandom_range(0, 1));
        wait_drain();
        write_reg(REG_SYMBOL_LEN, 32'd3);
        close_frame();

        wait_drain();
        if (errors == 0 && chirp_sample_q.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/bcfm_pkg.sv
rtl/bcfm_cos_rom.sv
rtl/binary_chirp_frame_modulator.sv
tb/sv/testbench.sv
